@@ sv/aes128_ctr_byte_stream_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the AES-128 CTR byte stream block
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef AES128_CTR_BYTE_STREAM_DEFINES_SVH
`define AES128_CTR_BYTE_STREAM_DEFINES_SVH

// A condition at one edge implies another at the same edge.
`define ACBS_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// A condition at one edge implies another at the next edge.
`define ACBS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

@@ sv/acbs_pkg.sv @@
// ----------------------------------------------------------------------------
// AES-128 CTR byte stream package
// S-box, round constants and AES round helpers shared by the modules.
// ----------------------------------------------------------------------------
package acbs_pkg;

	localparam int unsigned CfgW = 64;
	localparam int unsigned CfgIdxW = 2;
	localparam logic [CfgIdxW-1:0] REG_KEY_HIGH = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_KEY_LOW = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_CTR_HIGH = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_CTR_LOW = 2'd3;
	localparam int unsigned NumRounds = 10;
	localparam int unsigned RoundW = 4;
	localparam int unsigned QueueDepthDefault = 4;

	typedef logic [127:0] block_t;

	// Front-to-back queue entry.
	typedef struct packed {
		logic [7:0] data;
		logic [3:0] offset;
	} item_t;

	// Keystream handshake from the cipher unit.
	typedef struct packed {
		logic busy;
		logic done;
	} core_status_t;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] r;
		case (x)
		8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
		8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
		8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
		8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
		8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
		8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
		8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
		8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
		8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
		8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
		8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
		8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
		8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
		8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
		8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
		8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
		8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
		8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
		8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
		8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
		8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
		8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
		8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
		8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
		8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
		8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
		8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
		8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
		8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
		8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
		8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
		8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
		8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
		8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
		8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
		8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
		8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
		8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
		8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
		8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
		8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
		8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
		8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
		8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
		8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
		8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
		8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
		8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
		8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
		8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
		8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
		8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
		8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
		8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
		8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
		8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
		8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
		8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
		8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
		8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
		8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
		8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
		8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
		8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] rcon(input logic [RoundW-1:0] rnd);
		logic [7:0] r;
		case (rnd)
		4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
		4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
		4'd9: r = 8'h1b; 4'd10: r = 8'h36; default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte i of the state sits at bits [127-8i -: 8].
	function automatic logic [7:0] byte_at(input block_t s, input int i);
		return s[127-8*i -: 8];
	endfunction

	// Next round key from the previous one.
	function automatic block_t next_key(input block_t k, input logic [RoundW-1:0] rnd);
		logic [31:0] w0, w1, w2, w3, t;
		block_t r;
		w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
		t = {sbox(w3[23:16]), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
		t = t ^ {rcon(rnd), 24'h0};
		w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
		r = {w0, w1, w2, w3};
		return r;
	endfunction

	// One cipher round without the key addition.
	function automatic block_t round_fn(input block_t s, input logic last);
		block_t sb, sr, mc;
		logic [7:0] a0, a1, a2, a3, all;
		for (int i = 0; i < 16; i++) begin
			sb[127-8*i -: 8] = sbox(byte_at(s, i));
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				sr[127-8*(4*c+r) -: 8] = byte_at(sb, 4*((c+r)%4)+r);
			end
		end
		mc = sr;
		for (int c = 0; c < 4; c++) begin
			a0 = byte_at(sr, 4*c); a1 = byte_at(sr, 4*c+1);
			a2 = byte_at(sr, 4*c+2); a3 = byte_at(sr, 4*c+3);
			all = a0 ^ a1 ^ a2 ^ a3;
			mc[127-8*(4*c) -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
			mc[127-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
			mc[127-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			mc[127-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		return last ? sr : mc;
	endfunction

endpackage

@@ sv/aes128_ctr_byte_stream.sv @@
// ----------------------------------------------------------------------------
// AES-128 counter-mode byte stream cipher
// Top level: configuration registers, front end, queue and back end.
// ----------------------------------------------------------------------------
// Usage: bytes enter on valid/stall with data_in and restart; each beat
// returns data_in XOR the keystream byte at the current offset on the
// output valid/stall channel. Restart reloads the counter from the start
// registers and makes the beat the first of a new block.
// A beat at offset zero makes the block start AES-128 on the counter; the
// iterative core runs one round per cycle, and that beat leaves once the
// keystream block is captured. Other beats leave through the queue and the
// output register. Throughput is one beat per cycle inside a block while the
// receiver does not stall; at a block boundary the output is empty while the
// core works (start, 10 rounds, capture), and the input stalls once the
// queue holds QueueDepth beats.
// Configuration writes (key and counter start) take effect at once; the user
// must make them only while the block is idle; the block does not enforce it.
// Reset clears the counter, the offset, the queue and the output valid flag.
// When the receiver stalls, the output beat holds and the queue fills;
// once full, the input channel stalls.
// ----------------------------------------------------------------------------
`include "aes128_ctr_byte_stream_defines.svh"

module aes128_ctr_byte_stream #(
	parameter int unsigned QueueDepth = acbs_pkg::QueueDepthDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_in,
	input  logic       restart,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_out,
	input  logic       cfg_we,
	input  logic [acbs_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [acbs_pkg::CfgW-1:0] cfg_data
);
	import acbs_pkg::*;

	logic [63:0] key_high_q, key_low_q, ctr_high_q, ctr_low_q;
	logic q_full, q_push, restart_take;
	item_t q_item;

	// Configuration registers; all four indexes are defined.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			ctr_high_q <= '0;
			ctr_low_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
			REG_KEY_HIGH: key_high_q <= cfg_data;
			REG_KEY_LOW: key_low_q <= cfg_data;
			REG_CTR_HIGH: ctr_high_q <= cfg_data;
			REG_CTR_LOW: ctr_low_q <= cfg_data;
			default: ;
			endcase
		end
	end

	// The front end tags each beat with its offset and pushes it.
	acbs_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .stall(in_stall),
		.data_in(data_in), .restart(restart), .q_full(q_full),
		.q_push(q_push), .q_item(q_item), .restart_take(restart_take)
	);

	// The back end owns the queue, the counter and the AES core.
	acbs_back #(.QueueDepth(QueueDepth)) u_back (
		.clk(clk), .arst_n(arst_n), .q_push(q_push), .q_item(q_item),
		.restart_take(restart_take), .ctr_start({ctr_high_q, ctr_low_q}),
		.key({key_high_q, key_low_q}), .q_full(q_full), .valid(out_valid),
		.stall(out_stall), .data_out(data_out)
	);

	// A stalled output beat stays valid.
	`ACBS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "output beat dropped")
	// The input is stalled only when the queue is full.
	`ACBS_ASSERT_IMPL(a_stall_full, clk, arst_n, in_stall, q_full, "stall without full queue")
	// A restart beat is always pushed at offset zero.
	`ACBS_ASSERT_IMPL(a_restart_off, clk, arst_n, restart_take, q_item.offset == 4'd0, "restart offset")
endmodule

@@ sv/acbs_core.sv @@
// ----------------------------------------------------------------------------
// AES-128 iterative cipher core
// One round per cycle with on-the-fly key schedule.
// ----------------------------------------------------------------------------
module acbs_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  acbs_pkg::block_t key,
	input  acbs_pkg::block_t din,
	output acbs_pkg::block_t dout,
	output acbs_pkg::core_status_t status
);
	import acbs_pkg::*;

	logic [RoundW-1:0] round_q;
	logic busy_q, done_q;
	block_t state_q, rkey_q, rkey_nx, st_nx;

	assign rkey_nx = next_key(rkey_q, round_q);
	assign st_nx = round_fn(state_q, round_q == RoundW'(NumRounds)) ^ rkey_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			round_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				round_q <= RoundW'(1);
			end else if (busy_q) begin
				round_q <= round_q + RoundW'(1);
				if (round_q == RoundW'(NumRounds)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			state_q <= din ^ key;
			rkey_q <= key;
		end else if (busy_q) begin
			state_q <= st_nx;
			rkey_q <= rkey_nx;
		end
	end

	assign dout = state_q;
	assign status = '{busy: busy_q, done: done_q};
endmodule

@@ sv/acbs_front.sv @@
// ----------------------------------------------------------------------------
// Front end: accepts bytes and assigns each its keystream offset
// Tracks the offset, keeps the restart boundary and feeds the queue.
// ----------------------------------------------------------------------------
module acbs_front (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	output logic       stall,
	input  logic [7:0] data_in,
	input  logic       restart,
	input  logic       q_full,
	output logic       q_push,
	output acbs_pkg::item_t q_item,
	output logic       restart_take
);
	import acbs_pkg::*;

	logic [3:0] offset_q, offset_now;

	assign stall = q_full;
	assign q_push = valid && !q_full;
	assign offset_now = restart ? 4'd0 : offset_q;
	assign q_item = '{data: data_in, offset: offset_now};
	assign restart_take = q_push && restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (q_push) begin
			offset_q <= offset_now + 4'd1;
		end
	end
endmodule

@@ sv/acbs_back.sv @@
// ----------------------------------------------------------------------------
// Back end: keystream generation and byte XOR
// Pops queued bytes, refreshes the keystream block at offset zero.
// ----------------------------------------------------------------------------
module acbs_back #(
	parameter int unsigned QueueDepth = acbs_pkg::QueueDepthDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_push,
	input  acbs_pkg::item_t q_item,
	input  logic       restart_take,
	input  logic [127:0] ctr_start,
	input  acbs_pkg::block_t key,
	output logic       q_full,
	output logic       valid,
	input  logic       stall,
	output logic [7:0] data_out
);
	import acbs_pkg::*;

	localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

	item_t mem_q [QueueDepth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [PtrW:0] cnt_q;
	logic [127:0] ctr_q;
	block_t ks_q, core_out;
	core_status_t cst;
	logic ks_wait_q, out_v_q, pop, start;
	item_t head;

	// The counter used for a block is the counter at the time the byte at
	// offset zero is pushed; restart reloads before the push.
	logic [127:0] ctr_cur;
	logic need_blk_q;
	logic [127:0] blk_ctr;

	// Counter snapshots per queue entry: a ring of QueueDepth entries indexed like the queue.
	logic [127:0] ctr_ring_q [QueueDepth];

	assign ctr_cur = restart_take ? ctr_start : ctr_q;
	assign q_full = cnt_q == (PtrW+1)'(QueueDepth);
	assign head = mem_q[rd_q];
	assign valid = out_v_q;

	// The core loads the head's counter at the edge where start is high.
	assign blk_ctr = ctr_ring_q[rd_q];

	// Head at offset zero needs a fresh block before it can leave.
	assign start = (cnt_q != '0) && head.offset == 4'd0 && !ks_wait_q
		&& !cst.busy && need_blk_q;
	assign pop = (cnt_q != '0) && (!out_v_q || !stall) && !ks_wait_q
		&& !(head.offset == 4'd0 && need_blk_q);

	acbs_core u_core (
		.clk(clk), .arst_n(arst_n), .start(start), .key(key),
		.din(blk_ctr), .dout(core_out), .status(cst)
	);

	always_ff @(posedge clk) begin
		if (q_push) begin
			mem_q[wr_q] <= q_item;
			ctr_ring_q[wr_q] <= ctr_cur;
		end
		if (pop) begin
			data_out <= head.data ^ byte_at(ks_q, int'(head.offset));
		end
		if (cst.done) begin
			ks_q <= core_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
			ctr_q <= '0;
			out_v_q <= 1'b0;
			ks_wait_q <= 1'b0;
			need_blk_q <= 1'b1;
		end else begin
			if (q_push) begin
				wr_q <= (wr_q == PtrW'(QueueDepth-1)) ? '0 : wr_q + PtrW'(1);
				ctr_q <= (q_item.offset == 4'd0) ? ctr_cur + 128'd1 : ctr_cur;
			end
			if (pop) begin
				rd_q <= (rd_q == PtrW'(QueueDepth-1)) ? '0 : rd_q + PtrW'(1);
				need_blk_q <= 1'b1;
			end
			cnt_q <= cnt_q + (PtrW+1)'(q_push) - (PtrW+1)'(pop);
			if (start) begin
				ks_wait_q <= 1'b1;
			end
			if (cst.done) begin
				ks_wait_q <= 1'b0;
				need_blk_q <= 1'b0;
			end
			if (pop) begin
				out_v_q <= 1'b1;
			end else if (!stall) begin
				out_v_q <= 1'b0;
			end
		end
	end
endmodule
